// ===== design/cbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg
// Types, constants and helpers shared by the coverage bin packer modules.
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int unsigned CountBits  = 56;
  localparam int unsigned CountBytes = CountBits / 8;
  localparam int unsigned NumCounts  = 4;
  localparam int unsigned WidthBits  = 3;
  localparam int unsigned RemBits    = 5;
  localparam int unsigned OutAddrBits = 32;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [WidthBits-1:0] width_t;
  typedef logic [RemBits-1:0]   rem_t;

  // Arrangement of the count widths
  typedef enum logic [1:0] {
    ARR_NONE     = 2'd0,
    ARR_PAIR_TGT = 2'd2,
    ARR_PAIR_DIR = 2'd3
  } arr_e;

  // Input item
  typedef struct packed {
    count_t fwd_count;
    count_t rev_count;
    count_t fwd_target_count;
    count_t rev_target_count;
    logic   group_start;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [OutAddrBits-1:0] byte_address;
    logic [7:0]             byte_value;
    logic                   last_byte;
  } out_item_t;

  // Format decision for one bin
  typedef struct packed {
    logic [7:0]                  code;
    width_t [NumCounts-1:0]      widths;
    rem_t                        total;
  } fmt_t;

  // Work handed to the byte serializer
  typedef struct packed {
    logic                   new_run;
    logic [7:0]             code;
    logic [7:0]             run_count;
    count_t [NumCounts-1:0] counts;
    width_t [NumCounts-1:0] widths;
    rem_t                   total;
  } load_t;

  // Least number of bytes that hold a count
  function automatic width_t byte_width(input count_t v);
    width_t n;
    n = '0;
    for (int i = 0; i < CountBytes; i++) begin
      if (v[8*i +: 8] != 8'd0) begin
        n = WidthBits'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic width_t max_width(input width_t x, input width_t y);
    return (x > y) ? x : y;
  endfunction

endpackage

// ===== design/cbp_format.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_format
// Finds each count's byte width, picks the cheaper arrangement and builds
// the 8-bit format code with the per-count widths and their total.
// ----------------------------------------------------------------------------
module cbp_format (
  input  cbp_pkg::in_item_t item_i,
  output cbp_pkg::fmt_t     fmt_o
);

  cbp_pkg::width_t a, b, at, bt;
  cbp_pkg::width_t p2a, p2b, p3a, p3b;
  cbp_pkg::width_t wa, wb;
  logic [cbp_pkg::WidthBits:0] sum2, sum3;
  cbp_pkg::arr_e arr;

  // Measure the four counts
  assign a  = cbp_pkg::byte_width(item_i.fwd_count);
  assign b  = cbp_pkg::byte_width(item_i.rev_count);
  assign at = cbp_pkg::byte_width(item_i.fwd_target_count);
  assign bt = cbp_pkg::byte_width(item_i.rev_target_count);

  assign p2a = cbp_pkg::max_width(a, at);
  assign p2b = cbp_pkg::max_width(b, bt);
  assign p3a = cbp_pkg::max_width(a, b);
  assign p3b = cbp_pkg::max_width(at, bt);

  assign sum2 = {1'b0, p2a} + {1'b0, p2b};
  assign sum3 = {1'b0, p3a} + {1'b0, p3b};

  // Pick the arrangement; target pairing wins ties
  always_comb begin
    if ((item_i.fwd_target_count | item_i.rev_target_count) == '0) begin
      arr = cbp_pkg::ARR_NONE;
      wa  = a;
      wb  = b;
    end else if (sum2 <= sum3) begin
      arr = cbp_pkg::ARR_PAIR_TGT;
      wa  = p2a;
      wb  = p2b;
    end else begin
      arr = cbp_pkg::ARR_PAIR_DIR;
      wa  = p3a;
      wb  = p3b;
    end
  end

  // Widths in emit order F, R, Ft, Rt
  always_comb begin
    fmt_o.code = {arr, wb, wa};
    unique case (arr)
      cbp_pkg::ARR_PAIR_DIR: fmt_o.widths = {wb, wb, wa, wa};
      cbp_pkg::ARR_PAIR_TGT: fmt_o.widths = {wb, wa, wb, wa};
      default:               fmt_o.widths = {3'd0, 3'd0, wb, wa};
    endcase
    fmt_o.total = cbp_pkg::RemBits'(fmt_o.widths[0]) + cbp_pkg::RemBits'(fmt_o.widths[1])
                + cbp_pkg::RemBits'(fmt_o.widths[2]) + cbp_pkg::RemBits'(fmt_o.widths[3]);
  end

endmodule

// ===== design/cbp_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_emitter
// Byte serializer: sends the run header bytes and then the little-endian
// count bytes of one bin, one item per cycle while out_ready_i is high, with their store addresses.
// ----------------------------------------------------------------------------
module cbp_emitter #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  cbp_pkg::load_t        load_data_i,
  input  logic [ADDR_BITS-1:0]  load_head_i,
  input  logic [ADDR_BITS-1:0]  load_tail_i,
  output logic                  done_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cbp_pkg::out_item_t    out_item_o
);

  logic                            busy_q, busy_d;
  cbp_pkg::rem_t                   rem_q, rem_d;
  logic [1:0]                      hdr_q, hdr_d;
  logic                            new_q, new_d;
  logic [7:0]                      code_q, code_d;
  logic [7:0]                      runc_q, runc_d;
  logic [ADDR_BITS-1:0]            head_q, head_d;
  logic [ADDR_BITS-1:0]            tail_q, tail_d;
  cbp_pkg::count_t [cbp_pkg::NumCounts-1:0] cnt_q, cnt_d;
  cbp_pkg::width_t [cbp_pkg::NumCounts-1:0] w_q, w_d;

  logic       fire;
  logic [1:0] idx;
  logic [ADDR_BITS-1:0] addr;
  logic [7:0] value;

  assign fire   = busy_q && out_ready_i;
  assign done_o = !busy_q || (fire && (rem_q == cbp_pkg::RemBits'(1)));

  // Select the first count that still has bytes
  always_comb begin
    priority if (w_q[0] != '0) idx = 2'd0;
    else if (w_q[1] != '0)     idx = 2'd1;
    else if (w_q[2] != '0)     idx = 2'd2;
    else                       idx = 2'd3;
  end

  // Build the current byte
  always_comb begin
    if (hdr_q != 2'd0) begin
      if (new_q) begin
        value = (hdr_q == 2'd2) ? 8'd1 : code_q;
        addr  = tail_q;
      end else begin
        value = runc_q;
        addr  = head_q;
      end
    end else begin
      value = cnt_q[idx][7:0];
      addr  = tail_q;
    end
  end

  assign out_valid_o             = busy_q;
  assign out_item_o.byte_address = cbp_pkg::OutAddrBits'(addr);
  assign out_item_o.byte_value   = value;
  assign out_item_o.last_byte    = (rem_q == cbp_pkg::RemBits'(1));

  // Advance the sequence, or load the next bin
  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    hdr_d  = hdr_q;
    new_d  = new_q;
    code_d = code_q;
    runc_d = runc_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    w_d    = w_q;
    if (load_i) begin
      busy_d = 1'b1;
      new_d  = load_data_i.new_run;
      hdr_d  = load_data_i.new_run ? 2'd2 : 2'd1;
      rem_d  = load_data_i.total + (load_data_i.new_run ? cbp_pkg::RemBits'(2)
                                                         : cbp_pkg::RemBits'(1));
      code_d = load_data_i.code;
      runc_d = load_data_i.run_count;
      head_d = load_head_i;
      tail_d = load_tail_i;
      cnt_d  = load_data_i.counts;
      w_d    = load_data_i.widths;
    end else if (fire) begin
      rem_d = rem_q - cbp_pkg::RemBits'(1);
      if (rem_q == cbp_pkg::RemBits'(1)) begin
        busy_d = 1'b0;
      end
      if (hdr_q != 2'd0) begin
        hdr_d = hdr_q - 2'd1;
        if (new_q) begin
          tail_d = tail_q + ADDR_BITS'(1);
        end
      end else begin
        cnt_d[idx] = cnt_q[idx] >> 8;
        w_d[idx]   = w_q[idx] - cbp_pkg::WidthBits'(1);
        tail_d     = tail_q + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      hdr_q  <= '0;
      new_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      hdr_q  <= hdr_d;
      new_q  <= new_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    runc_q <= runc_d;
    head_q <= head_d;
    tail_q <= tail_d;
    cnt_q  <= cnt_d;
    w_q    <= w_d;
  end

`ifndef SYNTH
  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q != '0)
    else $error("serializer busy with no bytes left");

  a_rem_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q == cbp_pkg::RemBits'(hdr_q) + cbp_pkg::RemBits'(w_q[0])
      + cbp_pkg::RemBits'(w_q[1]) + cbp_pkg::RemBits'(w_q[2])
      + cbp_pkg::RemBits'(w_q[3]))
    else $error("byte count out of step with header and widths");

  a_cont_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !new_q) |-> hdr_q != 2'd2)
    else $error("continued run with two header bytes");

  a_stay_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rem_q != cbp_pkg::RemBits'(1)) |=> busy_q)
    else $error("serializer dropped a bin mid-sequence");
`endif

endmodule

// ===== design/coverage_bin_packer_unit.sv =====
`timescale 1ns / 1ps
// A taken item goes into the input register and then into the serializer.
// Throughput: a bin emits 1 or 2 header bytes plus its count bytes (up to 30 in
// all), one byte per cycle while out_ready_i is high; next bin follows at once.
// The input register takes the next bin while the current one is still sending.
// Reset (asynchronous, active low) clears the store tail, run head, run length
// and format code, and empties the input register and serializer.
// ----------------------------------------------------------------------------
// coverage_bin_packer_unit
// Run-length packer for four-way coverage bins: format choice, run tracking
// and byte serialization with store addresses.
// ----------------------------------------------------------------------------
module coverage_bin_packer_unit #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cbp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cbp_pkg::out_item_t out_item_o
);

  logic                 in_v_q;
  cbp_pkg::in_item_t    in_q;
  logic                 load;
  logic                 done;
  logic                 new_run;
  cbp_pkg::fmt_t        fmt;
  cbp_pkg::load_t       load_data;

  logic [ADDR_BITS-1:0] tail_q, tail_d;
  logic [ADDR_BITS-1:0] head_q, head_d;
  logic [7:0]           len_q, len_d;
  logic [7:0]           prev_q, prev_d;

  // Hold one bin ahead of the serializer
  assign load       = in_v_q && done;
  assign in_ready_o = !in_v_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  cbp_format u_format (
    .item_i (in_q),
    .fmt_o  (fmt)
  );

  // Open a new run or extend the current one
  assign new_run = in_q.group_start || (len_q == 8'd0) || (len_q == 8'd255)
                || (fmt.code != prev_q);

  always_comb begin
    tail_d = tail_q;
    head_d = head_q;
    len_d  = len_q;
    prev_d = prev_q;
    if (load) begin
      if (new_run) begin
        head_d = tail_q;
        len_d  = 8'd1;
        prev_d = fmt.code;
        tail_d = tail_q + ADDR_BITS'(fmt.total) + ADDR_BITS'(2);
      end else begin
        len_d  = len_q + 8'd1;
        tail_d = tail_q + ADDR_BITS'(fmt.total);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q <= '0;
      head_q <= '0;
      len_q  <= '0;
      prev_q <= '0;
    end else begin
      tail_q <= tail_d;
      head_q <= head_d;
      len_q  <= len_d;
      prev_q <= prev_d;
    end
  end

  // Hand the bin to the serializer
  always_comb begin
    load_data.new_run   = new_run;
    load_data.code      = fmt.code;
    load_data.run_count = len_d;
    load_data.counts    = {in_q.rev_target_count, in_q.fwd_target_count,
                           in_q.rev_count, in_q.fwd_count};
    load_data.widths    = fmt.widths;
    load_data.total     = fmt.total;
  end

  cbp_emitter #(
    .ADDR_BITS (ADDR_BITS)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_data_i (load_data),
    .load_head_i (head_q),
    .load_tail_i (tail_q),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coverage bin packer. A driver feeds bins from
// a queue over valid/ready; a packing predictor works out the store bytes
// each bin should produce, and a monitor compares every output byte against
// them in order. Directed corner bins come first, then random runs of
// same-format bins, noise bins and one run long enough to be closed at 255.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned      ADDR_BITS   = 32;
  localparam int unsigned      LIMIT       = 1_000_000;
  localparam int unsigned      HOLD_AT     = 30;
  localparam int unsigned      HOLD_CYCLES = 300;
  localparam int unsigned      DRAIN       = 20;
  localparam cbp_pkg::count_t  COUNT_MAX   = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cbp_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cbp_pkg::out_item_t out_item;

  // Stimulus and expectation stores
  cbp_pkg::in_item_t  pending_bins[$];
  cbp_pkg::out_item_t expected_bytes[$];
  cbp_pkg::out_item_t byte_want;

  // Predictor state
  logic [31:0] store_tail;
  logic [31:0] open_head;
  logic [7:0]  open_len;
  logic [7:0]  open_fmt;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 78;
  int unsigned bins_taken = 0;
  int unsigned bytes_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  coverage_bin_packer_unit #(
    .ADDR_BITS(ADDR_BITS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Least number of bytes holding a count, scanned from the top byte down
  function automatic cbp_pkg::width_t count_bytes(input cbp_pkg::count_t v);
    for (int i = cbp_pkg::CountBytes - 1; i >= 0; i--) begin
      if (v[8*i +: 8] != 8'd0) return cbp_pkg::width_t'(i + 1);
    end
    return '0;
  endfunction

  function automatic logic [31:0] addr_next(input logic [31:0] a);
    logic [63:0] mask;
    mask = (64'd1 << ADDR_BITS) - 64'd1;
    return 32'(({32'd0, a} + 64'd1) & mask);
  endfunction

  function automatic cbp_pkg::width_t wider(input cbp_pkg::width_t x,
                                            input cbp_pkg::width_t y);
    return (x > y) ? x : y;
  endfunction

  // Random count of exactly nbytes significant bytes
  function automatic cbp_pkg::count_t rand_count(input int unsigned nbytes);
    cbp_pkg::count_t v;
    v = '0;
    for (int i = 0; i < nbytes; i++) begin
      v[8*i +: 8] = (i == nbytes - 1) ? 8'($urandom_range(1, 255)) : 8'($urandom);
    end
    return v;
  endfunction

  function automatic void put_byte(input logic [31:0] addr, input logic [7:0] val);
    cbp_pkg::out_item_t b;
    b.byte_address = addr;
    b.byte_value   = val;
    b.last_byte    = 1'b0;
    expected_bytes.push_back(b);
  endfunction

  // Append a count little-endian at the store tail
  function automatic void put_count(input cbp_pkg::count_t v, input cbp_pkg::width_t nbytes);
    for (int i = 0; i < nbytes; i++) begin
      put_byte(store_tail, v[8*i +: 8]);
      store_tail = addr_next(store_tail);
    end
  endfunction

  // Work out every store byte that one accepted bin writes
  function automatic void pack_bin(input cbp_pkg::in_item_t bin);
    cbp_pkg::width_t wa;
    cbp_pkg::width_t wb;
    cbp_pkg::width_t wft;
    cbp_pkg::width_t wrt;
    int              pair_tgt;
    int              pair_dir;
    cbp_pkg::arr_e   arr;
    logic [7:0]      fmt;
    wa  = count_bytes(bin.fwd_count);
    wb  = count_bytes(bin.rev_count);
    arr = cbp_pkg::ARR_NONE;
    if ((bin.fwd_target_count | bin.rev_target_count) != '0) begin
      wft      = count_bytes(bin.fwd_target_count);
      wrt      = count_bytes(bin.rev_target_count);
      pair_tgt = int'(wider(wa, wft)) + int'(wider(wb, wrt));
      pair_dir = int'(wider(wa, wb)) + int'(wider(wft, wrt));
      // Pairing with the targets wins ties
      if (pair_tgt <= pair_dir) begin
        arr = cbp_pkg::ARR_PAIR_TGT;
        wa  = wider(wa, wft);
        wb  = wider(wb, wrt);
      end else begin
        arr = cbp_pkg::ARR_PAIR_DIR;
        wa  = wider(wa, wb);
        wb  = wider(wft, wrt);
      end
    end
    fmt = {arr, wb, wa};

    // Open a new run or bump the count byte of the open one
    if (bin.group_start || open_len == 8'd0 || open_len == 8'd255 || fmt != open_fmt) begin
      open_head = store_tail;
      put_byte(store_tail, 8'd1);
      store_tail = addr_next(store_tail);
      put_byte(store_tail, fmt);
      store_tail = addr_next(store_tail);
      open_len = 8'd1;
      open_fmt = fmt;
    end else begin
      open_len = open_len + 8'd1;
      put_byte(open_head, open_len);
    end

    put_count(bin.fwd_count, wa);
    if (arr == cbp_pkg::ARR_PAIR_DIR) begin
      put_count(bin.rev_count, wa);
      put_count(bin.fwd_target_count, wb);
      put_count(bin.rev_target_count, wb);
    end else begin
      put_count(bin.rev_count, wb);
      if (arr == cbp_pkg::ARR_PAIR_TGT) begin
        put_count(bin.fwd_target_count, wa);
        put_count(bin.rev_target_count, wb);
      end
    end
    expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
  endfunction

  function automatic void queue_bin(input cbp_pkg::count_t f, input cbp_pkg::count_t r,
                                    input cbp_pkg::count_t ft, input cbp_pkg::count_t rt,
                                    input logic gs);
    cbp_pkg::in_item_t b;
    b.fwd_count        = f;
    b.rev_count        = r;
    b.fwd_target_count = ft;
    b.rev_target_count = rt;
    b.group_start      = gs;
    pending_bins.push_back(b);
  endfunction

  // Random bins: mostly runs sharing one width set, some unrelated noise bins
  function automatic void queue_random(input int unsigned count);
    int unsigned queued;
    int unsigned run_bins;
    int unsigned w[4];
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(99) < 70) begin
        run_bins = $urandom_range(1, 12);
        if (run_bins > count - queued) run_bins = count - queued;
        foreach (w[i]) w[i] = $urandom_range(0, cbp_pkg::CountBytes);
        if ($urandom_range(3) == 0) begin
          w[2] = 0;
          w[3] = 0;
        end
        for (int k = 0; k < run_bins; k++) begin
          queue_bin(rand_count(w[0]), rand_count(w[1]), rand_count(w[2]), rand_count(w[3]),
                    (k == 0) ? 1'($urandom) : ($urandom_range(15) == 0));
        end
        queued += run_bins;
      end else begin
        queue_bin(rand_count($urandom_range(0, cbp_pkg::CountBytes)),
                  rand_count($urandom_range(0, cbp_pkg::CountBytes)),
                  rand_count($urandom_range(0, cbp_pkg::CountBytes)),
                  rand_count($urandom_range(0, cbp_pkg::CountBytes)), 1'($urandom));
        queued++;
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_bins.size() != 0 || in_valid || expected_bytes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: present queued bins, predict each one as it is taken
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pack_bin(in_item);
        bins_taken <= bins_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_bins.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_bins.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold the output off once for a long stretch so the input backs up
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bins_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare each output byte with the oldest expected one
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got addr 0x%0h value 0x%0h last %0b",
                   $time, out_item.byte_address, out_item.byte_value, out_item.last_byte);
          errors++;
        end else begin
          byte_want = expected_bytes.pop_front();
          check_field("byte_address", byte_want.byte_address, out_item.byte_address);
          check_field("byte_value", 32'(byte_want.byte_value), 32'(out_item.byte_value));
          check_field("last_byte", 32'(byte_want.last_byte), 32'(out_item.last_byte));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    store_tail = '0;
    open_head  = '0;
    open_len   = '0;
    open_fmt   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners
    queue_bin('0, '0, '0, '0, 1'b0);                        // first bin opens a run
    queue_bin('0, '0, '0, '0, 1'b0);                        // run grows, no count bytes
    queue_bin('0, '0, '0, '0, 1'b1);                        // group start forces header
    queue_bin(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);  // widest bin, tie
    queue_bin(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
    queue_bin(COUNT_MAX, '0, '0, '0, 1'b0);                 // forward only
    queue_bin('0, COUNT_MAX, '0, '0, 1'b0);                 // reverse only
    queue_bin(56'h80, 56'h100, '0, '0, 1'b0);
    queue_bin(COUNT_MAX, COUNT_MAX, 56'h1, 56'h1, 1'b0);    // direction pairing
    queue_bin(COUNT_MAX, 56'h1, COUNT_MAX, 56'h1, 1'b0);    // target pairing
    queue_bin('0, '0, 56'hFF, '0, 1'b0);                    // forward target only
    queue_bin('0, '0, '0, 56'h1234, 1'b0);                  // reverse target only
    queue_bin('0, '0, '0, 56'h5678, 1'b0);
    queue_bin(56'h12, 56'h3456, 56'h789A, 56'hBC, 1'b0);    // equal totals
    queue_bin(56'h01_0000_0000_0000, '0, '0, '0, 1'b0);
    queue_bin(56'hAA_AAAA_AAAA_AAAA, 56'h55_5555_5555_5555,
              56'hAA_AAAA_AAAA_AAAA, 56'h55_5555_5555_5555, 1'b1);
    queue_bin(56'h55_5555_5555_5555, 56'hAA_AAAA_AAAA_AAAA,
              56'h55_5555_5555_5555, 56'hAA_AAAA_AAAA_AAAA, 1'b0);
    queue_random(10);
    wait_drained();

    send_idle_pct = 78;
    recv_idle_pct = 38;
    queue_random(10);
    wait_drained();

    // Full speed: a run long enough to be closed at 255 bins
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 256; k++) begin
      queue_bin(rand_count(1), '0, '0, '0, k == 0);
    end
    wait_drained();

    repeat (DRAIN) @(posedge clk);
    $display("tb: %0d bins packed, %0d store bytes checked, %0d errors", bins_taken,
             bytes_seen, errors);
    $display("tb: covered all arrangements, run growth, group starts, a full run close");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== coverage_bin_packer_unit.f =====
design/cbp_pkg.sv
design/cbp_format.sv
design/cbp_emitter.sv
design/coverage_bin_packer_unit.sv
bench/tb_top.sv
